// File: src/integer_to_radix_digits_assert.svh
// Assertion macros for the checker file of this block.
`ifndef INTEGER_TO_RADIX_DIGITS_ASSERT_SVH
`define INTEGER_TO_RADIX_DIGITS_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ITRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ITRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/itrd_pkg.sv
package itrd_pkg;

  // Sizing of the conversion.
  localparam int VALUE_WIDTH   = 64;
  localparam int MAX_DIGITS    = 64;
  localparam int DIGIT_W       = 6;
  localparam int RADIX_W       = 6;
  localparam int CHAR_W        = 7;
  localparam int LEN_W         = 7;
  localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W        = $clog2(MAX_DIGITS);

  // The divider retires this many quotient bits per cycle.
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int DIV_W         = DIV_STEPS * BITS_PER_STEP;
  localparam int STEP_CNT_W    = $clog2(DIV_STEPS + 1);

  // Radix limits and the one radix that shows a sign.
  localparam logic [RADIX_W-1:0] RADIX_MIN    = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX    = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] RADIX_SIGNED = RADIX_W'(10);

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'h57;  // 'a' minus ten
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_e;

  // Request to the divider: start a division of dividend by radix.
  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [RADIX_W-1:0]     radix;
  } div_req_t;

  // Divider result, valid for the one cycle in which done is high.
  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } div_rsp_t;

  // Radix values outside 2..36 saturate to the nearest end.
  function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  // Digit value to lower-case ASCII.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DIGIT_W'(10)) begin
      res = CHAR_ZERO + CHAR_W'(d);
    end else begin
      res = CHAR_ALPHA + CHAR_W'(d);
    end
    return res;
  endfunction

endpackage

// File: src/itrd_divider.sv
module itrd_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  itrd_pkg::div_req_t req_i,
  output itrd_pkg::div_rsp_t rsp_o
);
  import itrd_pkg::*;

  logic [DIV_W-1:0]      work_q, work_d;
  logic [DIGIT_W-1:0]    rem_q, rem_d;
  logic [RADIX_W-1:0]    radix_q;
  logic [STEP_CNT_W-1:0] cnt_q;
  logic                  busy_q, done_q;

  // Restoring long division, several bits per cycle. The work register
  // shifts the dividend out at the top and the quotient bits in at the bottom.
  always_comb begin
    logic [DIGIT_W:0] r;
    work_d = work_q;
    rem_d  = rem_q;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      r      = {rem_d, work_d[DIV_W-1]};
      work_d = {work_d[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, radix_q}) begin
        r         = r - {1'b0, radix_q};
        work_d[0] = 1'b1;
      end
      rem_d = r[DIGIT_W-1:0];
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= STEP_CNT_W'(DIV_STEPS);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - STEP_CNT_W'(1);
      busy_q <= (cnt_q != STEP_CNT_W'(1));
      done_q <= (cnt_q == STEP_CNT_W'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      work_q  <= DIV_W'(req_i.dividend);
      rem_q   <= '0;
      radix_q <= req_i.radix;
    end else if (busy_q) begin
      work_q <= work_d;
      rem_q  <= rem_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = work_q[VALUE_WIDTH-1:0];
  assign rsp_o.remainder = rem_q;

endmodule

// File: src/itrd_digit_ram.sv
module itrd_digit_ram (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [itrd_pkg::ADDR_W-1:0]   wr_addr_i,
  input  logic [itrd_pkg::DIGIT_W-1:0]  wr_data_i,
  input  logic                          rd_en_i,
  input  logic [itrd_pkg::ADDR_W-1:0]   rd_addr_i,
  output logic [itrd_pkg::DIGIT_W-1:0]  rd_data_o
);
  import itrd_pkg::*;

  logic [DIGIT_W-1:0] mem [MAX_DIGITS];
  logic [DIGIT_W-1:0] rd_data_q;

  // Digit store, least significant digit at address zero.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/integer_to_radix_digits.sv
// Converts a 64-bit value to its lower-case ASCII digits in a radix from 2 to
// 36, most significant digit first, one character per output request, with
// last marking the final character and length giving the whole string length.
// Radix values below 2 or above 36 saturate. In signed mode a leading '-' is
// sent only for radix 10 and a negative value. The block takes one request at
// a time and stalls its input until the last character has left the digit
// store. Each digit takes one full division in the divider, which is restarted
// on the quotient for the next digit, and the characters then leave at one per
// cycle when the output is not stalled.
module integer_to_radix_digits (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [63:0]                    value_i,
  input  logic [itrd_pkg::RADIX_W-1:0]   radix_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [itrd_pkg::CHAR_W-1:0]    character_o,
  output logic                           last_o,
  output logic [itrd_pkg::LEN_W-1:0]     length_o
);
  import itrd_pkg::*;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic                 rd_valid_q, rd_valid_d;
  logic                 rd_last_q, rd_last_d;
  logic                 neg_q, neg_d;
  logic                 ov_q, ov_d;
  logic [RADIX_W-1:0]   radix_q;
  logic [CHAR_W-1:0]    char_q, char_d;
  logic                 last_q, last_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic                 out_load;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic                 ram_wr_en, ram_rd_en;
  logic [ADDR_W-1:0]    ram_rd_addr;
  logic [DIGIT_W-1:0]   ram_rd_data;

  logic [VALUE_WIDTH-1:0] in_val;
  logic [RADIX_W-1:0]     in_radix;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [CNT_W-1:0]       cnt_inc;
  logic [LEN_W-1:0]       str_len;
  logic                   out_free;
  logic                   move;

  // Input conditioning: saturate the radix and take the magnitude.
  assign in_val   = value_i[VALUE_WIDTH-1:0];
  assign in_radix = sat_radix(radix_i);
  assign in_neg   = mode_i && (in_radix == RADIX_SIGNED) && in_val[VALUE_WIDTH-1];
  assign in_mag   = in_neg ? (~in_val + VALUE_WIDTH'(1)) : in_val;

  assign cnt_inc  = cnt_q + CNT_W'(1);
  assign str_len  = LEN_W'(cnt_q) + LEN_W'(neg_q);
  assign out_free = !ov_q || !out_stall_i;
  assign move     = rd_valid_q && out_free;

  itrd_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  itrd_digit_ram u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (cnt_q[ADDR_W-1:0]),
    .wr_data_i (div_rsp.remainder),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign ram_rd_addr = ADDR_W'(rd_cnt_q - CNT_W'(1));

  // Sequencer: next state, divider control, store access and output loading.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    rd_cnt_d   = rd_cnt_q;
    rd_valid_d = rd_valid_q;
    rd_last_d  = rd_last_q;
    neg_d      = neg_q;
    div_req    = '{start: 1'b0, dividend: in_mag, radix: in_radix};
    ram_wr_en  = 1'b0;
    ram_rd_en  = 1'b0;
    out_load   = 1'b0;
    char_d     = char_q;
    last_d     = last_q;
    len_d      = len_q;
    in_stall_o = 1'b1;

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          div_req.start = 1'b1;
          cnt_d         = '0;
          neg_d         = in_neg;
          state_d       = ST_DIVIDE;
        end
      end

      ST_DIVIDE: begin
        if (div_rsp.done) begin
          ram_wr_en = 1'b1;
          cnt_d     = cnt_inc;
          if ((div_rsp.quotient != '0) && (cnt_inc < CNT_W'(MAX_DIGITS))) begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
            div_req.radix    = radix_q;
          end else begin
            rd_cnt_d = cnt_inc;
            state_d  = neg_q ? ST_SIGN : ST_EMIT;
          end
        end
      end

      ST_SIGN: begin
        if (out_free) begin
          out_load = 1'b1;
          char_d   = CHAR_MINUS;
          last_d   = 1'b0;
          len_d    = str_len;
          state_d  = ST_EMIT;
        end
      end

      ST_EMIT: begin
        // Read ahead one digit so a character can leave every cycle while the output is not stalled.
        if ((rd_cnt_q != '0) && (!rd_valid_q || move)) begin
          ram_rd_en  = 1'b1;
          rd_cnt_d   = rd_cnt_q - CNT_W'(1);
          rd_valid_d = 1'b1;
          rd_last_d  = (rd_cnt_q == CNT_W'(1));
        end else if (move) begin
          rd_valid_d = 1'b0;
        end
        if (move) begin
          out_load = 1'b1;
          char_d   = digit_to_char(ram_rd_data);
          last_d   = rd_last_q;
          len_d    = str_len;
        end
        if ((rd_cnt_q == '0) && !rd_valid_q) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    ov_d = ov_q;
    if (out_load) begin
      ov_d = 1'b1;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      rd_cnt_q   <= '0;
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
      neg_q      <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      rd_cnt_q   <= rd_cnt_d;
      rd_valid_q <= rd_valid_d;
      rd_last_q  <= rd_last_d;
      neg_q      <= neg_d;
      ov_q       <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      radix_q <= in_radix;
    end
    char_q <= char_d;
    last_q <= last_d;
    len_q  <= len_d;
  end

  assign out_valid_o = ov_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign length_o    = len_q;

endmodule

// File: src/itrd_checker.sv
module itrd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [itrd_pkg::CHAR_W-1:0]    character_o,
  input logic                           last_o,
  input logic [itrd_pkg::LEN_W-1:0]     length_o
);
  import itrd_pkg::*;

`include "integer_to_radix_digits_assert.svh"

  // A stalled result keeps its valid and its payload.
  `ITRD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(character_o) && $stable(last_o) && $stable(length_o))

  // Once a request is taken the input stays stalled while it is converted.
  `ITRD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // A minus sign never ends a string, and every string has at least one digit.
  `ITRD_ASSERT_NOW(a_sign_not_last, clk_i, rst_ni, out_valid_o && (character_o == CHAR_MINUS), !last_o && (length_o >= LEN_W'(2)))

  // Every character is a digit, a letter or the minus sign.
  `ITRD_ASSERT_NOW(a_char_legal, clk_i, rst_ni, out_valid_o, (character_o == CHAR_MINUS) || ((character_o >= CHAR_ZERO) && (character_o <= CHAR_ZERO + CHAR_W'(9))) || ((character_o >= CHAR_ALPHA + CHAR_W'(10)) && (character_o <= CHAR_ALPHA + CHAR_W'(35))))

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .character_o (character_o),
  .last_o      (last_o),
  .length_o    (length_o)
);

// File: tb/sv/tb_top.sv
module tb_top;
  import itrd_pkg::*;

  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;
  localparam int   MAX_GAP       = 13;
  localparam int   CYCLE_LIMIT   = 2500000;
  localparam int   DRAIN_CYCLES  = 700;
  localparam int   RANDOM_ITEMS  = 350;
  localparam int   BLOCK_ITEMS   = 50;

  // One character of a converted string, as the block should send it.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              is_last;
    logic [LEN_W-1:0]  total;
  } char_rec_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                mode_i      = 1'b0;
  logic [63:0]         value_i     = '0;
  logic [RADIX_W-1:0]  radix_i     = RADIX_MIN;
  logic                out_stall_i = 1'b1;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [CHAR_W-1:0]   character_o;
  logic                last_o;
  logic [LEN_W-1:0]    length_o;

  char_rec_t pending_chars[$];
  int        error_count = 0;
  int        cycle_count = 0;
  bit        sender_steady = 1'b0;
  bit        receiver_steady = 1'b0;

  integer_to_radix_digits dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .radix_i     (radix_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o),
    .length_o    (length_o)
  );

  always #10 clk_i = ~clk_i;

  // Work out the characters that one request turns into and queue them.
  function automatic void predict_string(input logic m, input logic [63:0] v,
                                         input logic [RADIX_W-1:0] r_raw);
    logic [RADIX_W-1:0] base;
    logic               minus;
    logic [63:0]        mag;
    logic [DIGIT_W-1:0] digs [MAX_DIGITS];
    int                 n;
    int                 k;
    char_rec_t          rec;
    base = r_raw;
    if (base < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (base > RADIX_MAX) begin
      base = RADIX_MAX;
    end
    minus = (m == MODE_SIGNED) && (base == RADIX_SIGNED) && v[63];
    mag = minus ? (~v + 64'd1) : v;
    n = 0;
    // Digits come out least significant first.
    do begin
      digs[n] = DIGIT_W'(mag % 64'(base));
      mag = mag / 64'(base);
      n++;
    end while (mag != 0 && n < MAX_DIGITS);
    rec.total = LEN_W'(n + (minus ? 1 : 0));
    if (minus) begin
      rec.ch = CHAR_MINUS;
      rec.is_last = 1'b0;
      pending_chars.push_back(rec);
    end
    for (k = n - 1; k >= 0; k--) begin
      rec.ch = (digs[k] < 10) ? CHAR_ZERO + CHAR_W'(digs[k]) : CHAR_ALPHA + CHAR_W'(digs[k]);
      rec.is_last = (k == 0);
      pending_chars.push_back(rec);
    end
  endfunction

  // Send one request after a random gap (none while the sender is steady) and record its characters once taken.
  task automatic send_number(input logic m, input logic [63:0] v,
                             input logic [RADIX_W-1:0] r);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_i    <= v;
    radix_i    <= r;
    do @(posedge clk_i); while (in_stall_o);
    predict_string(m, v, r);
  endtask

  // Output side: a random stall before each character, sometimes none at all.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      n = receiver_steady ? 0 : $urandom_range(0, MAX_GAP);
      out_stall_i <= (n != 0);
      if (n > 0) begin
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every accepted character with the oldest one still owed.
  always @(posedge clk_i) begin
    char_rec_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character: expected none, actual %h", $time, character_o);
        error_count++;
      end else begin
        want = pending_chars.pop_front();
        if (character_o !== want.ch) begin
          $display("%0t: character: expected %h, actual %h", $time, want.ch, character_o);
          error_count++;
        end
        if (last_o !== want.is_last) begin
          $display("%0t: last: expected %b, actual %b", $time, want.is_last, last_o);
          error_count++;
        end
        if (length_o !== want.total) begin
          $display("%0t: length: expected %0d, actual %0d", $time, want.total, length_o);
          error_count++;
        end
      end
    end
  end

  // Cycle counter that ends a run which has hung.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Zero, single digits, the widest strings and the highest digit letters.
  task automatic test_extremes();
    send_number(MODE_UNSIGNED, 64'd0, 6'd10);
    send_number(MODE_UNSIGNED, 64'd9, 6'd10);
    send_number(MODE_UNSIGNED, 64'd10, 6'd11);
    send_number(MODE_UNSIGNED, 64'd35, 6'd36);
    send_number(MODE_UNSIGNED, '1, 6'd2);
    send_number(MODE_UNSIGNED, '1, 6'd10);
    send_number(MODE_UNSIGNED, '1, 6'd36);
    send_number(MODE_UNSIGNED, 64'h8000_0000_0000_0000, 6'd16);
    send_number(MODE_UNSIGNED, 64'h0123_4567_89ab_cdef, 6'd16);
  endtask

  // Radix values outside two to thirty-six saturate to the nearest end.
  task automatic test_radix_saturation();
    send_number(MODE_UNSIGNED, 64'd5, 6'd0);
    send_number(MODE_UNSIGNED, 64'hff, 6'd1);
    send_number(MODE_UNSIGNED, 64'd1295, 6'd37);
    send_number(MODE_SIGNED, '1, 6'd63);
  endtask

  // A minus sign shows only for negative values in signed mode and radix ten.
  task automatic test_sign_handling();
    send_number(MODE_SIGNED, 64'h8000_0000_0000_0000, 6'd10);
    send_number(MODE_SIGNED, '1, 6'd10);
    send_number(MODE_SIGNED, 64'h7fff_ffff_ffff_ffff, 6'd10);
    send_number(MODE_SIGNED, 64'd0, 6'd10);
    send_number(MODE_SIGNED, '1, 6'd16);
    send_number(MODE_SIGNED, 64'hffff_ffff_ffff_fff6, 6'd2);
    send_number(MODE_UNSIGNED, 64'hffff_ffff_ffff_fffb, 6'd10);
  endtask

  // Random values of random width in random radixes, in blocks with and
  // without idle cycles on either side.
  task automatic test_random();
    int            i;
    int            w;
    logic [63:0]   v;
    logic [RADIX_W-1:0] r;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % BLOCK_ITEMS == 0) begin
        sender_steady   = ($urandom_range(0, 3) == 0);
        receiver_steady = ($urandom_range(0, 3) == 0);
      end
      v = {$urandom, $urandom};
      w = $urandom_range(1, 64);
      if ($urandom_range(0, 2) != 0) begin
        v = v & ({64{1'b1}} >> (64 - w));
      end
      if ($urandom_range(0, 9) == 0) begin
        r = RADIX_W'($urandom_range(0, 63));
      end else if ($urandom_range(0, 3) == 0) begin
        r = RADIX_SIGNED;
      end else begin
        r = RADIX_W'($urandom_range(2, 36));
      end
      send_number(logic'($urandom_range(0, 1)), v, r);
    end
    sender_steady   = 1'b0;
    receiver_steady = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_radix_saturation();
    test_sign_handling();
    test_random();
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
